>>> hw/rtl/decimal_string_to_scaled_int_defines.svh
// Assertion macros for the decimal string to scaled integer block.
// Depends on nothing; taken in by the files that assert.
`ifndef DECIMAL_STRING_TO_SCALED_INT_DEFINES_SVH
`define DECIMAL_STRING_TO_SCALED_INT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in decimal string converter");

// Next-cycle implication, disabled during reset.
`define DSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in decimal string converter");

`endif

>>> hw/rtl/dsi_pkg.sv
// Shared types and constants for the decimal string to scaled integer block.
// Depends on nothing.
`timescale 1ns / 1ps

package dsi_pkg;

    typedef enum logic [2:0] {
        STATUS_OK,
        STATUS_EMPTY,
        STATUS_BAD_CHAR,
        STATUS_WHOLE_RANGE,
        STATUS_TWO_POINTS
    } status_t;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] ROUND_DIGIT = 4'd5;

endpackage

>>> hw/rtl/decimal_string_to_scaled_int.sv
// Decimal string to scaled integer converter, top level.
// Depends on dsi_pkg and decimal_string_to_scaled_int_defines.svh.
//
// Usage:
//   The char channel (char_valid, char_stall) takes one request per string
//   character: has_char, text_char, last. last ends the string after its
//   character; a request with has_char low ends it at once (empty if no
//   character came before).
//   The result channel (result_valid, result_stall) gives one request per
//   string: status and the 128-bit value times 10^FRACTION_DIGITS, split
//   into value_high and value_low. The value is zero unless status is OK.
//   Throughput: one character per cycle unless a stalled result holds the
//   accumulators, strings back to back; each character runs through one
//   multiply-by-ten and add on the accumulators. The final request passes
//   through the input register, the accumulators and the result register.
//   While the receiver stalls, the result holds and characters are still
//   taken until a second finished string waits behind it; then char_stall
//   rises until the result is taken.
//   Reset clears the accumulators and both valid flags; a string or result
//   still in flight at reset is dropped.
`timescale 1ns / 1ps
`include "decimal_string_to_scaled_int_defines.svh"

module decimal_string_to_scaled_int #(
    parameter int FRACTION_DIGITS = 12,
    parameter int WHOLE_DIGITS    = 26
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  logic               has_char,
    input  logic [7:0]         text_char,
    input  logic               last,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         status,
    output logic signed [63:0] value_high,
    output logic [63:0]        value_low
);

    localparam int WACC_W = (WHOLE_DIGITS * 3402) / 1024 + 1;
    localparam int FRAC_W = (FRACTION_DIGITS * 3402) / 1024 + 1;
    localparam int WCNT_W = $clog2(WHOLE_DIGITS + 2);
    localparam int FCNT_W = $clog2(FRACTION_DIGITS + 2);
    localparam int WIDX_W = $clog2(FRACTION_DIGITS + 1);
    localparam int WN_W   = WACC_W + 4;
    localparam int FN_W   = FRAC_W + 4;

    typedef logic [FRACTION_DIGITS:0][63:0] weight_tbl_t;

    function automatic logic [127:0] pow10(input int k);
        logic [127:0] p;
        p = 128'd1;
        for (int i = 0; i < k; i++) begin
            p = p * 128'd10;
        end
        return p;
    endfunction

    function automatic weight_tbl_t weight_table();
        weight_tbl_t t;
        logic [63:0] p;
        p = 64'd1;
        for (int j = 0; j <= FRACTION_DIGITS; j++) begin
            t[j] = p;
            p = p * 64'd10;
        end
        return t;
    endfunction

    localparam weight_tbl_t WEIGHTS    = weight_table();
    localparam logic [WN_W-1:0] LIMIT  = WN_W'(pow10(WHOLE_DIGITS) - 128'd1);
    localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(pow10(FRACTION_DIGITS) - 128'd1);

    typedef struct packed {
        logic [127:0]       scaled;
        logic [WACC_W-1:0]  whole;
        logic               whole_over;
        logic [WCNT_W-1:0]  whole_count;
        logic [FRAC_W-1:0]  frac;
        logic [FCNT_W-1:0]  frac_count;
        logic               round_up;
        logic [1:0]         point_count;
        logic               negative;
        logic               first;
        logic               bad_char;
    } acc_t;

    localparam acc_t ACC_RESET = '{
        scaled: '0, whole: '0, whole_over: 1'b0, whole_count: '0, frac: '0,
        frac_count: '0, round_up: 1'b0, point_count: 2'd0, negative: 1'b0,
        first: 1'b1, bad_char: 1'b0
    };

    logic             item_valid_reg;
    logic             item_has_reg;
    logic [7:0]       item_char_reg;
    logic             item_last_reg;
    acc_t             acc_reg;
    acc_t             acc_next;
    logic             fin_reg;
    logic             result_valid_reg;
    dsi_pkg::status_t status_reg;
    dsi_pkg::status_t status_next;
    logic [127:0]     value_reg;
    logic [127:0]     value_next;

    logic             res_load;
    logic             acc_ready;
    logic             item_move;
    logic             char_take;

    assign res_load   = fin_reg && (!result_valid_reg || !result_stall);
    assign acc_ready  = !fin_reg || res_load;
    assign item_move  = item_valid_reg && acc_ready;
    assign char_stall = item_valid_reg && !acc_ready;
    assign char_take  = char_valid && !char_stall;

    // Accumulator update for one character.
    always_comb
    begin
        acc_t                base;
        logic [3:0]          digit;
        logic [WN_W-1:0]     whole_n;
        logic [FN_W-1:0]     frac_n;
        logic [FCNT_W-1:0]   widx;
        logic [67:0]         frac_term;
        logic [67:0]         whole_term;
        base       = fin_reg ? ACC_RESET : acc_reg;
        acc_next   = base;
        digit      = 4'(item_char_reg - dsi_pkg::CHAR_ZERO);
        whole_n    = {1'b0, base.whole, 3'b000} + {3'b000, base.whole, 1'b0} + WN_W'(digit);
        frac_n     = {1'b0, base.frac, 3'b000} + {3'b000, base.frac, 1'b0} + FN_W'(digit);
        widx       = FCNT_W'(FRACTION_DIGITS - 1) - base.frac_count;
        frac_term  = 68'(WEIGHTS[widx[WIDX_W-1:0]]) * 68'(digit);
        whole_term = 68'(WEIGHTS[FRACTION_DIGITS]) * 68'(digit);
        if (item_move && item_has_reg)
        begin
            acc_next.first = 1'b0;
            priority if (base.first && item_char_reg == dsi_pkg::CHAR_MINUS)
            begin
                acc_next.negative = 1'b1;
            end
            else if (item_char_reg == dsi_pkg::CHAR_POINT)
            begin
                if (base.point_count != 2'd2)
                begin
                    acc_next.point_count = base.point_count + 2'd1;
                end
            end
            else if (item_char_reg >= dsi_pkg::CHAR_ZERO &&
                     item_char_reg <= dsi_pkg::CHAR_NINE)
            begin
                if (base.point_count == 2'd0)
                begin
                    if (base.whole_count != WCNT_W'(WHOLE_DIGITS + 1))
                    begin
                        acc_next.whole_count = base.whole_count + WCNT_W'(1);
                    end
                    if (!base.whole_over)
                    begin
                        if (whole_n > LIMIT)
                        begin
                            acc_next.whole_over = 1'b1;
                        end
                        else
                        begin
                            acc_next.whole  = whole_n[WACC_W-1:0];
                            acc_next.scaled = {base.scaled[124:0], 3'b000}
                                            + {base.scaled[126:0], 1'b0}
                                            + 128'(whole_term);
                        end
                    end
                end
                else if (base.point_count == 2'd1)
                begin
                    if (base.frac_count < FCNT_W'(FRACTION_DIGITS))
                    begin
                        acc_next.frac       = frac_n[FRAC_W-1:0];
                        acc_next.scaled     = base.scaled + 128'(frac_term);
                        acc_next.frac_count = base.frac_count + FCNT_W'(1);
                    end
                    else if (base.frac_count == FCNT_W'(FRACTION_DIGITS))
                    begin
                        acc_next.round_up   = (digit >= dsi_pkg::ROUND_DIGIT);
                        acc_next.frac_count = base.frac_count + FCNT_W'(1);
                    end
                end
            end
            else
            begin
                acc_next.bad_char = 1'b1;
            end
        end
    end

    // Status and value of a finished string.
    always_comb
    begin
        logic         carry;
        logic [127:0] rounded;
        carry = acc_reg.round_up && acc_reg.frac == FRAC_MAX;
        priority if (acc_reg.first)
        begin
            status_next = dsi_pkg::STATUS_EMPTY;
        end
        else if (acc_reg.bad_char)
        begin
            status_next = dsi_pkg::STATUS_BAD_CHAR;
        end
        else if (acc_reg.point_count == 2'd0)
        begin
            status_next = (acc_reg.whole_count > WCNT_W'(WHOLE_DIGITS) || acc_reg.whole_over)
                        ? dsi_pkg::STATUS_WHOLE_RANGE : dsi_pkg::STATUS_OK;
        end
        else if (acc_reg.point_count != 2'd1)
        begin
            status_next = dsi_pkg::STATUS_TWO_POINTS;
        end
        else if (acc_reg.whole_over || (carry && WN_W'(acc_reg.whole) == LIMIT))
        begin
            status_next = dsi_pkg::STATUS_WHOLE_RANGE;
        end
        else
        begin
            status_next = dsi_pkg::STATUS_OK;
        end
        rounded = acc_reg.negative
                ? (~acc_reg.scaled + {127'd0, !acc_reg.round_up})
                : (acc_reg.scaled + {127'd0, acc_reg.round_up});
        value_next = (status_next == dsi_pkg::STATUS_OK) ? rounded : 128'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            fin_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            acc_reg          <= ACC_RESET;
        end
        else
        begin
            if (char_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (item_move)
            begin
                item_valid_reg <= 1'b0;
            end
            if (item_move || res_load)
            begin
                acc_reg <= acc_next;
            end
            if (item_move)
            begin
                fin_reg <= !item_has_reg || item_last_reg;
            end
            else if (res_load)
            begin
                fin_reg <= 1'b0;
            end
            if (res_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_take)
        begin
            item_has_reg  <= has_char;
            item_char_reg <= text_char;
            item_last_reg <= last;
        end
        if (res_load)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign value_high   = signed'(value_reg[127:64]);
    assign value_low    = value_reg[63:0];

    `DSI_ASSERT_NOW(a_error_zero_value, clk, rst_n,
        result_valid_reg && status_reg != dsi_pkg::STATUS_OK, value_reg == 128'd0)
    `DSI_ASSERT_NEXT(a_clear_after_finish, clk, rst_n,
        res_load && !item_move, acc_reg.first && !fin_reg)
    `DSI_ASSERT_NEXT(a_finish_waits, clk, rst_n,
        fin_reg && result_valid_reg && result_stall, fin_reg && result_valid_reg)

endmodule

>>> dv/testbench.sv
// Self-checking testbench for decimal_string_to_scaled_int: strings go in one character per
// request and each result is checked against a local fixed-point conversion model.
// Depends on dsi_pkg and the decimal_string_to_scaled_int top level.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC_DIGITS  = 12;
    localparam int WHOLE_DIGITS = 26;
    localparam int QUIET_START  = 200;
    localparam int QUIET_END    = 500;
    localparam int HOLD_START   = 900;
    localparam int HOLD_LEN     = 300;
    localparam int RANDOM_CHARS = 1400;

    typedef struct packed {
        logic       has;
        logic [7:0] ch;
        logic       lst;
    } char_req_t;

    typedef struct {
        dsi_pkg::status_t status;
        logic [63:0]      high;
        logic [63:0]      low;
    } scaled_result_t;

    logic               clk;
    logic               rst_n;
    logic               char_valid = 1'b0;
    logic               char_stall;
    logic               has_char = 1'b0;
    logic [7:0]         text_char = 8'h00;
    logic               last = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [2:0]         status;
    logic signed [63:0] value_high;
    logic [63:0]        value_low;

    char_req_t      char_requests[$];
    scaled_result_t scaled_results[$];
    char_req_t      next_req;
    logic           char_taken = 1'b0;
    logic           hold_off = 1'b0;
    int             cycle_count = 0;
    int             mismatches = 0;
    int             chars_taken = 0;
    int             strings_done = 0;
    int             status_seen[5];

    // predictor state
    logic [127:0] acc_whole;
    logic         whole_over;
    int           whole_cnt;
    logic [63:0]  acc_frac;
    int           frac_cnt;
    logic         round_flag;
    int           points;
    logic         neg_seen;
    logic         fresh;
    logic         bad_seen;

    decimal_string_to_scaled_int dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .has_char     (has_char),
        .text_char    (text_char),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .value_high   (value_high),
        .value_low    (value_low)
    );

    function automatic logic [127:0] pow_ten(input int n);
        logic [127:0] p;
        p = 128'd1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    task automatic clear_state();
        acc_whole  = '0;
        whole_over = 1'b0;
        whole_cnt  = 0;
        acc_frac   = '0;
        frac_cnt   = 0;
        round_flag = 1'b0;
        points     = 0;
        neg_seen   = 1'b0;
        fresh      = 1'b1;
        bad_seen   = 1'b0;
    endtask

    task automatic convert_char(input logic has, input logic [7:0] ch, input logic lst);
        logic [127:0]   grown;
        logic [127:0]   w;
        logic [63:0]    f;
        logic [7:0]     d;
        scaled_result_t res;
        d = ch - dsi_pkg::CHAR_ZERO;
        if (has)
        begin
            if (fresh && ch == dsi_pkg::CHAR_MINUS)
            begin
                neg_seen = 1'b1;
            end
            else if (ch == dsi_pkg::CHAR_POINT)
            begin
                if (points < 2)
                    points++;
            end
            else if (ch >= dsi_pkg::CHAR_ZERO && ch <= dsi_pkg::CHAR_NINE)
            begin
                if (points == 0)
                begin
                    if (whole_cnt < WHOLE_DIGITS + 1)
                        whole_cnt++;
                    if (!whole_over)
                    begin
                        grown = acc_whole * 10 + d;
                        if (grown > pow_ten(WHOLE_DIGITS) - 1)
                            whole_over = 1'b1;
                        else
                            acc_whole = grown;
                    end
                end
                else if (points == 1)
                begin
                    if (frac_cnt < FRAC_DIGITS)
                    begin
                        acc_frac = acc_frac * 10 + d;
                        frac_cnt++;
                    end
                    else if (frac_cnt == FRAC_DIGITS)
                    begin
                        round_flag = (d >= dsi_pkg::ROUND_DIGIT);
                        frac_cnt++;
                    end
                end
            end
            else
            begin
                bad_seen = 1'b1;
            end
            fresh = 1'b0;
            if (!lst)
                return;
        end
        res.high = '0;
        res.low  = '0;
        if (fresh)
            res.status = dsi_pkg::STATUS_EMPTY;
        else if (bad_seen)
            res.status = dsi_pkg::STATUS_BAD_CHAR;
        else if (points == 0 && (whole_cnt > WHOLE_DIGITS || whole_over))
            res.status = dsi_pkg::STATUS_WHOLE_RANGE;
        else if (points >= 2)
            res.status = dsi_pkg::STATUS_TWO_POINTS;
        else
        begin
            w = acc_whole;
            f = '0;
            if (points == 1)
            begin
                f = acc_frac;
                for (int i = frac_cnt; i < FRAC_DIGITS; i++)
                begin
                    f = f * 10;
                end
                if (round_flag)
                begin
                    f = f + 1;
                    if (f >= pow_ten(FRAC_DIGITS))
                    begin
                        f = '0;
                        w = w + 1;
                    end
                end
            end
            if (whole_over || w > pow_ten(WHOLE_DIGITS) - 1)
                res.status = dsi_pkg::STATUS_WHOLE_RANGE;
            else
            begin
                res.status = dsi_pkg::STATUS_OK;
                w = w * pow_ten(FRAC_DIGITS) + f;
                if (neg_seen)
                    w = -w;
                res.high = w[127:64];
                res.low  = w[63:0];
            end
        end
        scaled_results.insert(scaled_results.size(), res);
        clear_state();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    endtask

    task automatic queue_char(input logic has, input logic [7:0] ch, input logic lst);
        char_req_t r;
        r.has = has;
        r.ch  = ch;
        r.lst = lst;
        char_requests.insert(char_requests.size(), r);
    endtask

    task automatic emit_text(input logic [7:0] text[$], input bit close_empty);
        for (int i = 0; i < text.size(); i++)
        begin
            queue_char(1'b1, text[i], (i == text.size() - 1) && !close_empty);
        end
        if (close_empty)
            queue_char(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic add_text(input string s, input bit close_empty);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++)
        begin
            text.insert(text.size(), s[i]);
        end
        emit_text(text, close_empty);
    endtask

    task automatic add_digits(ref logic [7:0] text[$], input int n, input int nines);
        for (int i = 0; i < n; i++)
        begin
            if (nines != 0)
                text.insert(text.size(), dsi_pkg::CHAR_NINE);
            else
                text.insert(text.size(), dsi_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        end
    endtask

    task automatic add_random_text();
        logic [7:0] text[$];
        int         pick;
        int         nines;
        pick  = $urandom_range(99);
        nines = ($urandom_range(19) == 0);
        if (pick < 85)
        begin
            if ($urandom_range(1))
                text.insert(text.size(), dsi_pkg::CHAR_MINUS);
            if (nines != 0)
                add_digits(text, WHOLE_DIGITS, 1);
            else if ($urandom_range(9) == 0)
                add_digits(text, $urandom_range(20, 28), 0);
            else
                add_digits(text, $urandom_range(0, 6), 0);
            if (nines != 0 || $urandom_range(99) < 70)
            begin
                text.insert(text.size(), dsi_pkg::CHAR_POINT);
                if (nines != 0)
                begin
                    add_digits(text, FRAC_DIGITS, 1);
                    add_digits(text, 1, 0);
                end
                else
                    add_digits(text, $urandom_range(0, 15), 0);
            end
        end
        else
        begin
            for (int i = $urandom_range(1, 8); i > 0; i--)
            begin
                case ($urandom_range(3))
                    0: text.insert(text.size(), 8'($urandom_range(255)));
                    1: text.insert(text.size(), dsi_pkg::CHAR_ZERO + 8'($urandom_range(9)));
                    2: text.insert(text.size(), dsi_pkg::CHAR_POINT);
                    default: text.insert(text.size(), dsi_pkg::CHAR_MINUS);
                endcase
            end
        end
        emit_text(text, text.size() == 0 || $urandom_range(9) == 0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #3_000_000;
        $display("decimal_string_to_scaled_int verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        hold_off    <= (cycle_count >= HOLD_START) && (cycle_count < HOLD_START + HOLD_LEN);
    end

    // driver: advance only once the current request has been taken
    always @(negedge clk)
    begin
        if (!rst_n)
            char_valid <= 1'b0;
        else if (!char_valid || char_taken)
        begin
            if (char_requests.size() != 0 &&
                !(!(cycle_count >= QUIET_START && cycle_count < QUIET_END) &&
                  $urandom_range(99) < 9))
            begin
                next_req = char_requests.pop_front();
                char_valid <= 1'b1;
                has_char   <= next_req.has;
                text_char  <= next_req.ch;
                last       <= next_req.lst;
            end
            else
                char_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        result_stall <= hold_off ||
                        (!(cycle_count >= QUIET_START && cycle_count < QUIET_END) &&
                         $urandom_range(99) < 9);
    end

    always @(posedge clk)
    begin
        char_taken <= rst_n && char_valid && !char_stall;
        if (rst_n && char_valid && !char_stall)
        begin
            chars_taken++;
            convert_char(has_char, text_char, last);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (scaled_results.size() == 0)
                report_mismatch("unexpected result", {61'd0, status}, '0);
            else
            begin
                automatic scaled_result_t want = scaled_results.pop_front();
                strings_done++;
                if (status < 5)
                    status_seen[status]++;
                if (status !== want.status)
                    report_mismatch("status", {61'd0, status}, {61'd0, want.status});
                if (value_high !== want.high)
                    report_mismatch("value_high", value_high, want.high);
                if (value_low !== want.low)
                    report_mismatch("value_low", value_low, want.low);
            end
        end
    end

    initial
    begin
        clear_state();
        for (int i = 0; i < 5; i++)
        begin
            status_seen[i] = 0;
        end
        add_text("0", 0);
        add_text("-0", 0);
        add_text("-0.0", 0);
        queue_char(1'b0, 8'hA5, 1'b1);
        queue_char(1'b0, 8'h00, 1'b0);
        add_text("-", 0);
        add_text(".", 0);
        add_text("-.", 0);
        add_text("123.456", 0);
        add_text("99999999999999999999999999", 0);
        add_text("100000000000000000000000000", 0);
        add_text("00000000000000000000000000001", 0);
        add_text("0000000000000000000000000000001.5", 0);
        add_text("99999999999999999999999999.9999999999995", 0);
        add_text("-99999999999999999999999999.999999999999", 0);
        add_text("1.9999999999995", 0);
        add_text("0.0000000000004", 0);
        add_text("0.0000000000015", 0);
        add_text("1.2.3", 0);
        add_text("12a", 0);
        add_text("1-2", 0);
        add_text("--1", 0);
        add_text("a..", 0);
        add_text("1.5", 1);
        queue_char(1'b1, 8'hFF, 1'b1);
        queue_char(1'b1, 8'h00, 1'b1);
        while (char_requests.size() < RANDOM_CHARS)
        begin
            add_random_text();
        end

        @(posedge clk);
        while (!rst_n || char_requests.size() != 0 || char_valid)
            @(posedge clk);
        while (scaled_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d strings over %0d character requests,",
                 strings_done, chars_taken);
        $display("with a %0d-cycle hold-off; ok %0d, empty %0d, bad char %0d, %s %0d, %s %0d.",
                 HOLD_LEN, status_seen[0], status_seen[1], status_seen[2],
                 "range", status_seen[3], "two points", status_seen[4]);
        if (mismatches == 0)
            $display("decimal_string_to_scaled_int verification clean");
        else
            $display("decimal_string_to_scaled_int verification failed");
        $finish;
    end

endmodule
